FILE: design/cbnp_pkg.sv
// Shared constants, types and codes of the custom base number parser.
package cbnp_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 32;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int SYMS_W      = 2 * CFG_DATA_W;
    localparam int DIGIT_W     = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN    = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] digit;
    } t_match;

endpackage

FILE: design/cbnp_ifs.sv
// Handshake channel interfaces: characters in, values out, configuration writes.
interface cbnp_char_if;
    logic                            valid;
    logic                            ready;
    logic [cbnp_pkg::CHAR_W-1:0]     char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface cbnp_value_if;
    logic                            valid;
    logic                            ready;
    logic signed [cbnp_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface cbnp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cbnp_pkg::CFG_IDX_W-1:0]    index;
    logic [cbnp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/cbnp_alphabet.sv
// Alphabet check and digit lookup against the configured symbol table.
module cbnp_alphabet (
    input  logic [cbnp_pkg::SYMS_W-1:0] i_symbols,
    input  logic [cbnp_pkg::LEN_W-1:0]  i_length,
    input  logic [cbnp_pkg::CHAR_W-1:0] i_char,
    output logic [cbnp_pkg::LEN_W-1:0]  o_used,
    output logic                        o_alpha_ok,
    output cbnp_pkg::t_match            o_match
);

    logic [cbnp_pkg::CHAR_W-1:0] w_sym [cbnp_pkg::MAX_SYMBOLS];

    always_comb begin
        for (int i = 0; i < cbnp_pkg::MAX_SYMBOLS; i++) begin
            w_sym[i] = i_symbols[i*cbnp_pkg::CHAR_W +: cbnp_pkg::CHAR_W];
        end
    end

    // Clamp the length to the table size
    assign o_used = (i_length > cbnp_pkg::LEN_W'(cbnp_pkg::MAX_SYMBOLS))
                  ? cbnp_pkg::LEN_W'(cbnp_pkg::MAX_SYMBOLS) : i_length;

    always_comb begin
        o_alpha_ok = (i_length >= cbnp_pkg::LEN_W'(2))
                  && (i_length <= cbnp_pkg::LEN_W'(cbnp_pkg::MAX_SYMBOLS));
        for (int i = 0; i < cbnp_pkg::MAX_SYMBOLS; i++) begin
            if (cbnp_pkg::LEN_W'(i) < o_used) begin
                if (w_sym[i] <= cbnp_pkg::CH_SPACE || w_sym[i] >= cbnp_pkg::CH_DEL
                        || w_sym[i] == cbnp_pkg::CH_PLUS || w_sym[i] == cbnp_pkg::CH_MINUS) begin
                    o_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < cbnp_pkg::MAX_SYMBOLS; j++) begin
                    if (cbnp_pkg::LEN_W'(j) < o_used && w_sym[j] == w_sym[i]) begin
                        o_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // Walk down so the lowest matching index wins
    always_comb begin
        o_match.hit   = 1'b0;
        o_match.digit = '0;
        for (int i = cbnp_pkg::MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (cbnp_pkg::LEN_W'(i) < o_used && w_sym[i] == i_char) begin
                o_match.hit   = 1'b1;
                o_match.digit = cbnp_pkg::DIGIT_W'(i);
            end
        end
    end

endmodule

FILE: design/custom_base_number_parser_core.sv
// Top level of the custom base number parser: registers, parse control, result stage.
//
// Usage:
//   i_char carries one character per transfer; a zero character ends the string.
//   o_value carries one signed 32-bit result per string, sent when the zero
//   character is processed; other characters produce no result.
//   i_cfg writes the alphabet: index 0 symbols 0..7, index 1 symbols 8..15,
//   index 2 the alphabet length (the base). Write only while no string is open.
//   An invalid alphabet makes every result 0.
// Timing:
//   A character is captured in an input register and processed from it; the
//   result enters the output register as the zero character is processed.
//   One character per cycle is taken sustained unless a zero character waits
//   on a result; the digit match and the multiply-add by the base share a cycle.
// Reset:
//   Clears the alphabet registers (invalid alphabet), the parse state and both
//   stage valid flags.
// Stall:
//   While a result waits, non-zero characters keep flowing; a following zero
//   character waits in the input register and i_char.ready drops until the
//   result is taken.
module custom_base_number_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cbnp_cfg_if.sink           i_cfg,
    cbnp_char_if.sink          i_char,
    cbnp_value_if.source       o_value
);

    logic [cbnp_pkg::CFG_DATA_W-1:0] r_sym_lo;
    logic [cbnp_pkg::CFG_DATA_W-1:0] r_sym_hi;
    logic [cbnp_pkg::LEN_W-1:0]      r_len;
    logic                            r_alpha_ok;

    logic                            r_in_valid;
    logic [cbnp_pkg::CHAR_W-1:0]     r_char;

    cbnp_pkg::t_phase                r_phase;
    cbnp_pkg::t_phase                n_phase;
    logic                            r_neg;
    logic                            n_neg;
    logic [cbnp_pkg::VALUE_W-1:0]    r_acc;
    logic [cbnp_pkg::VALUE_W-1:0]    n_acc;

    logic                            r_out_valid;
    logic [cbnp_pkg::VALUE_W-1:0]    r_value;
    logic [cbnp_pkg::VALUE_W-1:0]    n_value;

    logic [cbnp_pkg::LEN_W-1:0]      w_used;
    logic                            w_alpha_ok;
    cbnp_pkg::t_match                w_match;
    logic                            w_term;
    logic                            w_ws;
    logic                            w_sign;
    logic                            w_fire;
    logic                            w_emit;
    logic                            w_in_xfer;

    cbnp_alphabet u_alphabet (
        .i_symbols  ({r_sym_hi, r_sym_lo}),
        .i_length   (r_len),
        .i_char     (r_char),
        .o_used     (w_used),
        .o_alpha_ok (w_alpha_ok),
        .o_match    (w_match)
    );

    // Configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lo   <= '0;
            r_sym_hi   <= '0;
            r_len      <= '0;
            r_alpha_ok <= 1'b0;
        end else begin
            r_alpha_ok <= w_alpha_ok;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    cbnp_pkg::CFG_SYMBOLS_LOW:  r_sym_lo <= i_cfg.data;
                    cbnp_pkg::CFG_SYMBOLS_HIGH: r_sym_hi <= i_cfg.data;
                    cbnp_pkg::CFG_ALPHA_LEN:    r_len    <= i_cfg.data[cbnp_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Stage control
    assign w_term    = (r_char == cbnp_pkg::CH_NUL);
    assign w_ws      = (r_char >= cbnp_pkg::CH_TAB && r_char <= cbnp_pkg::CH_CR)
                    || (r_char == cbnp_pkg::CH_SPACE);
    assign w_sign    = (r_char == cbnp_pkg::CH_PLUS) || (r_char == cbnp_pkg::CH_MINUS);
    assign w_fire    = r_in_valid && (!w_term || !r_out_valid || o_value.ready);
    assign w_emit    = w_fire && w_term;
    assign w_in_xfer = i_char.valid && i_char.ready;

    assign i_char.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_xfer || (r_in_valid && !w_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_char <= i_char.char_in;
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            if (w_term) begin
                n_phase = cbnp_pkg::PH_SKIP;
            end else begin
                unique case (r_phase)
                    cbnp_pkg::PH_SKIP,
                    cbnp_pkg::PH_SIGN: begin
                        if (r_phase == cbnp_pkg::PH_SKIP && w_ws) begin
                            n_phase = cbnp_pkg::PH_SKIP;
                        end else if (w_sign) begin
                            n_phase = cbnp_pkg::PH_SIGN;
                        end else if (w_match.hit) begin
                            n_phase = cbnp_pkg::PH_DIGIT;
                        end else begin
                            n_phase = cbnp_pkg::PH_STOP;
                        end
                    end
                    cbnp_pkg::PH_DIGIT: begin
                        n_phase = w_match.hit ? cbnp_pkg::PH_DIGIT : cbnp_pkg::PH_STOP;
                    end
                    cbnp_pkg::PH_STOP:  n_phase = cbnp_pkg::PH_STOP;
                    default:            n_phase = cbnp_pkg::PH_SKIP;
                endcase
            end
        end
    end

    // Sign, accumulator and result
    always_comb begin
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_value = r_acc;
        if (r_neg) begin
            n_value = cbnp_pkg::VALUE_W'(0) - r_acc;
        end
        if (!r_alpha_ok) begin
            n_value = '0;
        end
        if (w_fire) begin
            if (w_term) begin
                n_neg = 1'b0;
                n_acc = '0;
            end else if (r_phase != cbnp_pkg::PH_STOP
                    && !(r_phase == cbnp_pkg::PH_SKIP && w_ws)) begin
                if ((r_phase == cbnp_pkg::PH_SKIP || r_phase == cbnp_pkg::PH_SIGN) && w_sign) begin
                    n_neg = r_neg ^ (r_char == cbnp_pkg::CH_MINUS);
                end else if (w_match.hit) begin
                    n_acc = cbnp_pkg::VALUE_W'(r_acc * cbnp_pkg::VALUE_W'(w_used))
                          + cbnp_pkg::VALUE_W'(w_match.digit);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cbnp_pkg::PH_SKIP;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_emit || (r_out_valid && !o_value.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_value <= n_value;
        end
    end

    assign o_value.valid = r_out_valid;
    assign o_value.value = r_value;

    // Checks
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_phase == cbnp_pkg::PH_SKIP) && !r_neg && (r_acc == '0))
        else $error("parse state not cleared after terminator");

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_term && r_phase == cbnp_pkg::PH_STOP)
        |=> (r_phase == cbnp_pkg::PH_STOP) && $stable(r_acc) && $stable(r_neg))
        else $error("stopped parse changed state");

    a_in_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |-> (!r_in_valid || w_fire))
        else $error("input register overwritten");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || o_value.ready))
        else $error("result register overwritten");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !r_alpha_ok) |=> (r_value == '0))
        else $error("invalid alphabet gave nonzero result");

endmodule
